### hw/rtl/assist_display_frame_decoder_unit_assert.svh
// Assertion macros for the assist display frame decoder checker.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef ASSIST_DISPLAY_FRAME_DECODER_UNIT_ASSERT_SVH
`define ASSIST_DISPLAY_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ADFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ADFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/adfd_pkg.sv
// Shared constants, command/status types and wheel table for the frame decoder.
// No dependencies.
`default_nettype none

package adfd_pkg;

    localparam int          FRAME_DEPTH   = 13;
    localparam logic [3:0]  BUF_DEPTH     = 4'd13;
    localparam logic [3:0]  DISP_LEN      = 4'd13;
    localparam logic [3:0]  CTRL_LEN      = 4'd12;
    localparam logic [7:0]  DISP_END      = 8'h0E;
    localparam logic [7:0]  CTRL_START    = 8'h41;
    localparam logic [15:0] SLOW_ROT      = 16'd6895;
    localparam logic [15:0] SPEED_MAX     = 16'hFFFF;
    localparam logic [2:0]  DEFAULT_LEVEL = 3'd3;
    localparam logic [6:0]  LIMIT_BASE    = 7'd10;
    localparam logic [17:0] CIRC_DEFAULT  = 18'd206000;

    localparam int NUM_W     = 22;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = 22;
    localparam int CNT_W     = 5;
    localparam int TDATA_W   = 64;

    localparam logic LINK_DISP   = 1'b0;
    localparam logic LINK_CTRL   = 1'b1;
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

    function automatic logic [17:0] circ_lookup(input logic [4:0] code);
        logic [17:0] circ;
        case (code)
            5'd0:    circ = 18'd126736;
            5'd2:    circ = 18'd94791;
            5'd4:    circ = 18'd142708;
            5'd6:    circ = 18'd110764;
            5'd8:    circ = 18'd157639;
            5'd10:   circ = 18'd62847;
            5'd12:   circ = 18'd174305;
            5'd14:   circ = 18'd78819;
            5'd16:   circ = 18'd189583;
            5'd18:   circ = 18'd46875;
            5'd24:   circ = 18'd217361;
            5'd28:   circ = 18'd219444;
            5'd30:   circ = 18'd225000;
            default: circ = CIRC_DEFAULT;
        endcase
        return circ;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/adfd_ctrl.sv
// Sequencer for the frame decoder: accept, divide, hand result to output register.
// Depends on adfd_pkg.
`default_nettype none

module adfd_ctrl import adfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.need_div ? ST_DIV : ST_SEND;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/adfd_dpath.sv
// Datapath: frame buffer, framing, field decode, serial speed divider, output register.
// Depends on adfd_pkg.
`default_nettype none

module adfd_dpath import adfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_action,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_source_link,
    output logic [TDATA_W-1:0] o_tdata,
    output logic               o_tlast,
    output logic               o_tuser
);

    logic [7:0]       r_buf [FRAME_DEPTH];
    logic [3:0]       r_pos;
    logic             r_link;
    logic             r_light;
    logic [2:0]       r_level;
    logic [6:0]       r_limit;
    logic [17:0]      r_circ;
    logic [11:0]      r_power;
    logic             r_brake;
    logic [15:0]      r_speed;
    logic             r_done;
    logic             r_kind;

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;

    logic [TDATA_W-1:0] r_tdata;
    logic               r_tlast;
    logic               r_tuser;

    logic             is_byte;
    logic [3:0]       pos0, pos1, n_pos;
    logic             wr_en, done;
    logic [7:0]       byte0;
    logic [15:0]      rot;
    logic [4:0]       disp_code;
    logic [6:0]       disp_limit;
    logic [11:0]      ctrl_power;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;

    logic [DEN_W:0]   shifted, diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_num;
    logic             div_last;

    assign is_byte = (i_action == ACT_BYTE) && (i_source_link == r_link);

    always_comb begin
        byte0 = r_buf[0];
        if (r_link == LINK_DISP) begin
            pos0  = (r_pos >= DISP_LEN) ? 4'd0 : r_pos;
            wr_en = 1'b1;
            pos1  = pos0 + 4'd1;
            done  = (pos1 == DISP_LEN) && (i_rx_byte == DISP_END);
            n_pos = ((pos1 >= DISP_LEN) || (i_rx_byte == DISP_END)) ? 4'd0 : pos1;
        end else begin
            pos0  = (i_rx_byte == CTRL_START) ? 4'd0 : r_pos;
            wr_en = (pos0 < BUF_DEPTH);
            pos1  = pos0 + 4'd1;
            if (pos0 == 4'd0) begin
                byte0 = i_rx_byte;
            end
            done  = wr_en && (pos1 >= CTRL_LEN) && (byte0 == CTRL_START);
            n_pos = wr_en ? pos1 : pos0;
        end
    end

    assign rot        = {r_buf[3], r_buf[4]};
    assign disp_code  = {r_buf[2][2:0], r_buf[4][7:6]};
    assign disp_limit = LIMIT_BASE + {1'b0, r_buf[4][5], r_buf[2][7:3]};
    assign ctrl_power = ({4'd0, r_buf[8]} << 3) + ({4'd0, r_buf[8]} << 2)
                      + {4'd0, r_buf[8]};
    assign div_num    = ({4'd0, r_circ} << 4) + ({4'd0, r_circ} << 1);
    assign div_den    = {rot[13:0], 2'b00} + rot;

    assign o_sts.need_div = is_byte && done && (r_link == LINK_CTRL)
                          && (rot != 16'd0) && (rot < SLOW_ROT);

    assign shifted  = {r_rem, r_num[NUM_W-1]};
    assign ge       = (shifted >= {1'b0, r_den});
    assign diff     = shifted - {1'b0, r_den};
    assign n_rem    = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    assign n_num    = {r_num[NUM_W-2:0], ge};
    assign div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign o_sts.div_last = div_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                r_buf[i] <= 8'd0;
            end
            r_pos   <= 4'd0;
            r_link  <= LINK_DISP;
            r_light <= 1'b0;
            r_level <= DEFAULT_LEVEL;
            r_limit <= 7'd0;
            r_circ  <= 18'd0;
            r_power <= 12'd0;
            r_brake <= 1'b0;
            r_speed <= 16'd0;
            r_done  <= 1'b0;
            r_kind  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_done <= is_byte && done;
            r_kind <= is_byte && done && r_link;
            if (i_action == ACT_TIMEOUT) begin
                r_light <= 1'b0;
                r_level <= DEFAULT_LEVEL;
                r_limit <= 7'd0;
                r_circ  <= 18'd0;
                r_power <= 12'd0;
                r_brake <= 1'b0;
                r_speed <= 16'd0;
            end else if (is_byte) begin
                if (done) begin
                    for (int i = 0; i < FRAME_DEPTH; i++) begin
                        r_buf[i] <= 8'd0;
                    end
                    r_pos  <= 4'd0;
                    r_link <= ~r_link;
                    if (r_link == LINK_DISP) begin
                        r_light <= r_buf[1][7];
                        r_level <= r_buf[1][2:0];
                        r_limit <= disp_limit;
                        r_circ  <= circ_lookup(disp_code);
                    end else begin
                        r_power <= ctrl_power;
                        r_brake <= r_buf[7][5];
                        if (rot >= SLOW_ROT) begin
                            r_speed <= 16'd0;
                        end else if (rot == 16'd0) begin
                            r_speed <= SPEED_MAX;
                        end
                    end
                end else begin
                    if (wr_en) begin
                        r_buf[pos0] <= i_rx_byte;
                    end
                    r_pos <= n_pos;
                end
            end
        end else if (i_cmd.div_step && div_last) begin
            r_speed <= (n_num[NUM_W-1:16] != '0) ? SPEED_MAX : n_num[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_num <= div_num;
            r_den <= div_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_tdata <= {5'd0, r_speed, r_brake, r_power, r_circ, r_limit, r_level,
                        r_light, r_link};
            r_tlast <= r_done;
            r_tuser <= r_kind;
        end
    end

    assign o_tdata = r_tdata;
    assign o_tlast = r_tlast;
    assign o_tuser = r_tuser;

endmodule

`default_nettype wire

### hw/rtl/assist_display_frame_decoder_unit.sv
// Each accepted byte goes from IDLE to SEND, where the result word is registered once
// the output slot is free; a controller frame whose rotation time needs the 22-step
// serial speed divider passes through DIV in between. A new word is accepted only in
// IDLE, and may be accepted while the previous result still waits downstream.
// Reset: synchronous active-low i_rst_n clears framing, listens to the display link,
// and restores decoded defaults (assist level 3, all else 0).
`default_nettype none

module assist_display_frame_decoder_unit import adfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]         s_axis_tuser,   // [0] action, [1] source_link
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] listen_link, [1] light_on, [4:2] assist_level, [11:5] speed_limit,
    // [29:12] wheel_circ, [41:30] motor_power, [42] brake_on, [58:43] ground_speed
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,   // frame_done
    output logic               m_axis_tuser    // [0] frame_kind
);

    t_cmd cmd;
    t_sts sts;

    adfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    adfd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (s_axis_tuser[0]),
        .i_rx_byte     (s_axis_tdata),
        .i_source_link (s_axis_tuser[1]),
        .o_tdata       (m_axis_tdata),
        .o_tlast       (m_axis_tlast),
        .o_tuser       (m_axis_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/adfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
// Depends on adfd_pkg and assist_display_frame_decoder_unit_assert.svh.
`default_nettype none
`include "assist_display_frame_decoder_unit_assert.svh"

module adfd_checker import adfd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               m_axis_tuser
);

    `ADFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `ADFD_ASSERT_SAME(a_done_switch, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[0] != m_axis_tuser, "link not switched after frame")
    `ADFD_ASSERT_SAME(a_kind_idle, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == 1'b0,
        "frame kind set without frame")
    `ADFD_ASSERT_SAME(a_limit_range, m_axis_tvalid, (m_axis_tdata[11:5] == 7'd0)
        || ((m_axis_tdata[11:5] >= 7'd10) && (m_axis_tdata[11:5] <= 7'd73)),
        "speed limit out of range")
    `ADFD_ASSERT_NEXT(a_in_single, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input word accepted back to back")

endmodule

bind assist_display_frame_decoder_unit adfd_checker u_adfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
